[rtl/cdb_pkg.sv]
package cdb_pkg;

	// Ring geometry. Pointers address one slot, counts reach the full depth.
	localparam int MAX_DEPTH = 256;
	localparam int ELEM_W    = 8;
	localparam int PTR_W     = $clog2(MAX_DEPTH);
	localparam int CNT_W     = PTR_W + 1;

	// Fixed field widths of the item and result.
	localparam int OP_W = 4;
	localparam int ST_W = 3;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [ST_W-1:0]   st_t;

	localparam op_t OP_PUSH_BACK  = 4'd0;
	localparam op_t OP_PUSH_FRONT = 4'd1;
	localparam op_t OP_POP_BACK   = 4'd2;
	localparam op_t OP_POP_FRONT  = 4'd3;
	localparam op_t OP_READ_AT    = 4'd4;
	localparam op_t OP_READ_FRONT = 4'd5;
	localparam op_t OP_READ_BACK  = 4'd6;
	localparam op_t OP_INSERT     = 4'd7;
	localparam op_t OP_ERASE      = 4'd8;
	localparam op_t OP_CLEAR      = 4'd9;

	localparam st_t ST_OK    = 3'd0;
	localparam st_t ST_FULL  = 3'd1;
	localparam st_t ST_EMPTY = 3'd2;
	localparam st_t ST_RANGE = 3'd3;
	localparam st_t ST_ERASE = 3'd4;

endpackage

[rtl/cdb_ram.sv]
module cdb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/cdb_ring_add.sv]
module cdb_ring_add (
	input  cdb_pkg::cnt_t cap,
	input  cdb_pkg::ptr_t base,
	input  cdb_pkg::cnt_t offset,
	output cdb_pkg::ptr_t result
);
	import cdb_pkg::*;

	// base is below cap and offset is at most cap, so the sum stays below twice
	// the capacity and a single conditional subtract reduces it.
	logic [CNT_W:0] sum;
	logic [CNT_W:0] cap_x;
	logic [CNT_W:0] red;

	assign sum   = {2'b00, base} + {1'b0, offset};
	assign cap_x = {1'b0, cap};
	assign red   = (sum >= cap_x) ? (sum - cap_x) : sum;
	assign result = red[PTR_W-1:0];

endmodule

[rtl/circular_deque_buffer_top.sv]
// Ring-buffer double-ended queue of bytes.
// Commands arrive on the s_ stream, one transfer per command; each command gives
// exactly one result transfer on the m_ stream, in order. Commands push or pop at
// either end, read at a logical index or at either end, insert at a position,
// erase a range, or clear. A failing command reports its status and changes nothing.
// The cfg port sets the number of ring slots in use (0 is taken as 1, values above
// the depth as the depth); a write empties the buffer. Writes are to be made while
// idle; the block itself does not enforce this. A command is taken only while the
// sequencer is idle, so the next command waits until the result of the last one is
// in the output register. Insert and erase move stored bytes one at a time through
// the single-port-read slot RAM, each byte read, then written back; insert moves
// the leading bytes when the position lies in the front half, else the trailing
// bytes, and erase moves the elements after the range. Slot addresses come from one
// shared ring adder (add, compare, subtract), apart from push back and read front,
// which use the tail and head pointers directly.
// After reset the buffer is empty and the capacity is 256; the slot RAM has no
// clearing pass since a slot is never read before it is written.
// The result sits in an output register. If the receiver stalls, the next command
// is still accepted and worked on, and its result waits until the register frees.
module circular_deque_buffer_top (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration: capacity in use.
	input  logic                 cfg_we,
	input  logic [8:0]           cfg_wdata,
	// Command stream. s_tdata: opcode[3:0], value[11:4], index[20:12],
	// index_end[29:21], zero fill[31:30].
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,
	// Result stream. m_tdata: read_data[7:0], status[10:8], fill_count[19:11],
	// is_full[20], is_empty[21], zero fill[23:22].
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata
);
	import cdb_pkg::*;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MRD  = 3'd2;
	localparam logic [2:0] S_MWR  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;

	// Latched command.
	op_t   op_q;
	elem_t val_q;
	cnt_t  idx_q;
	cnt_t  idx_end_q;

	// Ring state.
	ptr_t  head_q;
	ptr_t  tail_q;
	cnt_t  count_q;
	cnt_t  cap_q;

	// Move loop: logical source and destination, bytes left, direction.
	cnt_t  src_q;
	cnt_t  dst_q;
	cnt_t  moves_q;
	logic  up_q;

	logic  rd_sel_q;
	st_t   status_q;
	logic  m_tvalid_q;
	logic [23:0] m_tdata_q;

	// Shared ring adder.
	ptr_t  ring_base;
	cnt_t  ring_off;
	ptr_t  ring_out;

	// Slot RAM ports.
	logic  ram_we;
	ptr_t  ram_waddr;
	elem_t ram_wdata;
	logic  ram_re;
	ptr_t  ram_raddr;
	elem_t ram_rdata;

	st_t   st_c;
	logic  full_c;
	logic  empty_c;
	logic  front_c;
	cnt_t  cap_m1_c;
	cnt_t  erase_left_c;
	cnt_t  cap_new_c;
	elem_t rd_c;
	logic  out_free_c;

	assign full_c       = (count_q >= cap_q);
	assign empty_c      = (count_q == '0);
	assign front_c      = (idx_q < (count_q >> 1));
	assign cap_m1_c     = cap_q - cnt_t'(1);
	assign erase_left_c = count_q - (idx_end_q - idx_q);
	assign out_free_c   = !m_tvalid_q || m_tready;
	assign rd_c         = rd_sel_q ? ram_rdata : '0;

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_new_c = cnt_t'(1);
		end else if (cfg_wdata > cnt_t'(MAX_DEPTH)) begin
			cap_new_c = cnt_t'(MAX_DEPTH);
		end else begin
			cap_new_c = cfg_wdata;
		end
	end

	// Error checks on the latched command against the current ring state.
	always_comb begin
		st_c = ST_OK;
		case (op_q)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full_c) st_c = ST_FULL;
			end
			OP_POP_BACK, OP_POP_FRONT, OP_READ_FRONT, OP_READ_BACK: begin
				if (empty_c) st_c = ST_EMPTY;
			end
			OP_READ_AT: begin
				if (idx_q >= count_q) st_c = ST_RANGE;
			end
			OP_INSERT: begin
				if (idx_q > count_q) st_c = ST_RANGE;
				else if (full_c) st_c = ST_FULL;
			end
			OP_ERASE: begin
				if (idx_end_q > count_q) st_c = ST_RANGE;
				else if (idx_q >= idx_end_q) st_c = ST_ERASE;
			end
			default: st_c = ST_OK;
		endcase
	end

	// Operand selection for the ring adder. At rest it computes head + count,
	// which must equal the tail pointer.
	always_comb begin
		ring_base = head_q;
		ring_off  = count_q;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_PUSH_BACK: begin
						ring_base = tail_q;
						ring_off  = cnt_t'(1);
					end
					OP_PUSH_FRONT: ring_off = cap_m1_c;
					OP_POP_BACK, OP_READ_BACK: begin
						ring_base = tail_q;
						ring_off  = cap_m1_c;
					end
					OP_POP_FRONT: ring_off = cnt_t'(1);
					OP_READ_AT:   ring_off = idx_q;
					OP_INSERT: begin
						if (front_c) begin
							ring_off = cap_m1_c;
						end else begin
							ring_base = tail_q;
							ring_off  = cnt_t'(1);
						end
					end
					default: ring_off = count_q;
				endcase
			end
			S_MRD: ring_off = src_q;
			S_MWR: ring_off = dst_q;
			S_FIN: ring_off = (op_q == OP_INSERT) ? idx_q : erase_left_c;
			default: ring_off = count_q;
		endcase
	end

	cdb_ring_add u_ring (
		.cap    (cap_q),
		.base   (ring_base),
		.offset (ring_off),
		.result (ring_out)
	);

	// Slot RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ring_out;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = ring_out;
		case (state_q)
			S_EXEC: begin
				if (st_c == ST_OK) begin
					case (op_q)
						OP_PUSH_BACK: begin
							ram_we    = 1'b1;
							ram_waddr = tail_q;
						end
						OP_PUSH_FRONT: ram_we = 1'b1;
						OP_READ_AT, OP_READ_BACK: ram_re = 1'b1;
						OP_READ_FRONT: begin
							ram_re    = 1'b1;
							ram_raddr = head_q;
						end
						default: ram_we = 1'b0;
					endcase
				end
			end
			S_MRD: ram_re = 1'b1;
			S_MWR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			S_FIN: ram_we = (op_q == OP_INSERT);
			default: ram_we = 1'b0;
		endcase
	end

	cdb_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and ring state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			cap_q      <= cnt_t'(MAX_DEPTH);
			src_q      <= '0;
			dst_q      <= '0;
			moves_q    <= '0;
			up_q       <= 1'b0;
			rd_sel_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free_c) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				cap_q   <= cap_new_c;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rd_sel_q <= (st_c == ST_OK) && ((op_q == OP_READ_AT) ||
						(op_q == OP_READ_FRONT) || (op_q == OP_READ_BACK));
					if (st_c == ST_OK) begin
						case (op_q)
							OP_PUSH_BACK: begin
								tail_q  <= ring_out;
								count_q <= count_q + cnt_t'(1);
								state_q <= S_DONE;
							end
							OP_PUSH_FRONT: begin
								head_q  <= ring_out;
								count_q <= count_q + cnt_t'(1);
								state_q <= S_DONE;
							end
							OP_POP_BACK: begin
								tail_q  <= ring_out;
								count_q <= count_q - cnt_t'(1);
								state_q <= S_DONE;
							end
							OP_POP_FRONT: begin
								head_q  <= ring_out;
								count_q <= count_q - cnt_t'(1);
								state_q <= S_DONE;
							end
							OP_READ_AT, OP_READ_FRONT, OP_READ_BACK: begin
								state_q <= S_DONE;
							end
							OP_INSERT: begin
								if (front_c) begin
									// Leading bytes slide down one slot under a new head.
									head_q  <= ring_out;
									src_q   <= cnt_t'(1);
									dst_q   <= '0;
									moves_q <= idx_q;
									up_q    <= 1'b1;
									state_q <= (idx_q != '0) ? S_MRD : S_FIN;
								end else begin
									// Trailing bytes slide up one slot, last one first.
									tail_q  <= ring_out;
									src_q   <= count_q - cnt_t'(1);
									dst_q   <= count_q;
									moves_q <= count_q - idx_q;
									up_q    <= 1'b0;
									state_q <= (count_q != idx_q) ? S_MRD : S_FIN;
								end
							end
							OP_ERASE: begin
								src_q   <= idx_end_q;
								dst_q   <= idx_q;
								moves_q <= count_q - idx_end_q;
								up_q    <= 1'b1;
								state_q <= (count_q != idx_end_q) ? S_MRD : S_FIN;
							end
							OP_CLEAR: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					moves_q <= moves_q - cnt_t'(1);
					if (up_q) begin
						src_q <= src_q + cnt_t'(1);
						dst_q <= dst_q + cnt_t'(1);
					end else begin
						src_q <= src_q - cnt_t'(1);
						dst_q <= dst_q - cnt_t'(1);
					end
					state_q <= (moves_q == cnt_t'(1)) ? S_FIN : S_MRD;
				end
				S_FIN: begin
					if (op_q == OP_INSERT) begin
						count_q <= count_q + cnt_t'(1);
					end else begin
						count_q <= erase_left_c;
						tail_q  <= ring_out;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free_c) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command latch and result payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= s_tdata[3:0];
			val_q     <= s_tdata[11:4];
			idx_q     <= s_tdata[20:12];
			idx_end_q <= s_tdata[29:21];
		end
		if (state_q == S_EXEC) begin
			status_q <= st_c;
		end
		if (state_q == S_DONE && out_free_c) begin
			m_tdata_q <= {2'b00, (count_q == '0), (count_q == cap_q), count_q, status_q, rd_c};
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The element count never passes the capacity in use.
	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("element count above capacity in use");

	// Both pointers stay inside the ring.
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q < cap_q) && (tail_q < cap_q))
		else $error("ring pointer outside capacity in use");

	// At rest the tail sits exactly count slots after the head.
	a_tail_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (ring_out == tail_q))
		else $error("tail pointer out of step with head and count");

	// A write-back step always follows its read step.
	a_move_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MWR) |-> ($past(state_q) == S_MRD))
		else $error("move write without a preceding read");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for the ring-buffer deque. Commands go in on the s_ stream and
// results come back on the m_ stream, one result transfer per command transfer, in
// order. A behavioral copy of the deque runs beside the block. It is updated at every
// accepted command, and its answer is queued until the matching result arrives.
module testbench;
	import cdb_pkg::*;

	// Opcodes above clear have no meaning. The block must treat them as no-ops.
	localparam op_t OP_SPARE_LOW  = 4'd10;
	localparam op_t OP_SPARE_HIGH = 4'd15;

	// One result as it travels in m_tdata, lowest field last in the list.
	typedef struct packed {
		logic  is_empty;
		logic  is_full;
		cnt_t  fill_count;
		st_t   status;
		elem_t read_data;
	} res_t;

	// One line of the directed table. A line either writes the capacity or sends a
	// command. When typed is set, the expected result is written into the line itself.
	typedef struct packed {
		logic       is_cfg;
		logic [8:0] cfg_value;
		op_t        opcode;
		elem_t      value;
		logic [8:0] index;
		logic [8:0] index_end;
		logic       typed;
		res_t       result;
	} row_t;

	// Command mixes for the random part. The fill mix only pushes, inserts and reads,
	// so the buffer climbs to full even at the largest capacity.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_FILL} mix_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;

	// Contents and pointers of the deque as the bench expects them to be.
	elem_t ring_slots [MAX_DEPTH];
	int    ring_head = 0;
	int    ring_tail = 0;
	int    ring_fill = 0;
	int    ring_span = MAX_DEPTH;

	// Results that are owed by the block, oldest first.
	res_t  owed_results [$];
	row_t  directed_rows [$];
	int    mismatches = 0;

	// Sender pacing: transfers in bursts, then an idle gap.
	int    burst_left = 0;

	// Receiver pacing. A long hold is requested by the stimulus and counted out by
	// the receiver process on its own.
	int    hold_requests = 0;
	int    holds_served  = 0;
	int    hold_left     = 0;
	int    ready_mode    = 0;
	int    mode_left     = 0;
	int    rx_cycle      = 0;

	circular_deque_buffer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Guard against a hung block. A correct run finishes far earlier than this.
	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Physical slot of a logical position, counted from the head.
	function automatic int slot_of(input int logical);
		return (ring_head + logical) % ring_span;
	endfunction

	// Applies one command to the expected deque and returns the result it must give.
	// A command that fails leaves the contents and pointers exactly as they were.
	task automatic apply_to_ring(input op_t op, input elem_t v, input logic [8:0] ix,
			input logic [8:0] ixe, output res_t r);
		int i;
		int pos;
		int last;
		int cnt;
		bit was_full;
		bit was_empty;
		pos = ix;
		last = ixe;
		r = '0;
		r.status = ST_OK;
		was_full = ring_fill >= ring_span;
		was_empty = ring_fill == 0;
		case (op)
			OP_PUSH_BACK: begin
				if (was_full) begin
					r.status = ST_FULL;
				end else begin
					ring_slots[ring_tail] = v;
					ring_tail = (ring_tail + 1) % ring_span;
					ring_fill++;
				end
			end
			OP_PUSH_FRONT: begin
				if (was_full) begin
					r.status = ST_FULL;
				end else begin
					ring_head = (ring_head + ring_span - 1) % ring_span;
					ring_slots[ring_head] = v;
					ring_fill++;
				end
			end
			OP_POP_BACK: begin
				if (was_empty) begin
					r.status = ST_EMPTY;
				end else begin
					ring_tail = (ring_tail + ring_span - 1) % ring_span;
					ring_fill--;
				end
			end
			OP_POP_FRONT: begin
				if (was_empty) begin
					r.status = ST_EMPTY;
				end else begin
					ring_head = (ring_head + 1) % ring_span;
					ring_fill--;
				end
			end
			OP_READ_AT: begin
				if (pos >= ring_fill) r.status = ST_RANGE;
				else r.read_data = ring_slots[slot_of(pos)];
			end
			OP_READ_FRONT: begin
				if (was_empty) r.status = ST_EMPTY;
				else r.read_data = ring_slots[ring_head];
			end
			OP_READ_BACK: begin
				if (was_empty) r.status = ST_EMPTY;
				else r.read_data = ring_slots[(ring_tail + ring_span - 1) % ring_span];
			end
			OP_INSERT: begin
				// The position is checked before fullness.
				if (pos > ring_fill) begin
					r.status = ST_RANGE;
				end else if (was_full) begin
					r.status = ST_FULL;
				end else begin
					// A position in the front half moves the leading elements down and the
					// head back; otherwise the elements from the position on move up.
					if (pos < ring_fill / 2) begin
						ring_head = (ring_head + ring_span - 1) % ring_span;
						for (i = 0; i < pos; i++)
							ring_slots[slot_of(i)] = ring_slots[slot_of(i + 1)];
					end else begin
						ring_tail = (ring_tail + 1) % ring_span;
						for (i = ring_fill; i > pos; i--)
							ring_slots[slot_of(i)] = ring_slots[slot_of(i - 1)];
					end
					ring_slots[slot_of(pos)] = v;
					ring_fill++;
				end
			end
			OP_ERASE: begin
				// An end past the stored elements wins over an empty or inverted range.
				if (last > ring_fill) begin
					r.status = ST_RANGE;
				end else if (pos >= last) begin
					r.status = ST_ERASE;
				end else begin
					cnt = last - pos;
					for (i = last; i < ring_fill; i++)
						ring_slots[slot_of(i - cnt)] = ring_slots[slot_of(i)];
					ring_fill -= cnt;
					ring_tail = slot_of(ring_fill);
				end
			end
			OP_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				ring_fill = 0;
			end
			default: begin
			end
		endcase
		r.fill_count = cnt_t'(ring_fill);
		r.is_full = ring_fill == ring_span;
		r.is_empty = ring_fill == 0;
	endtask

	// Offers one command and holds it until the block takes it. A gap before a
	// burst drops tvalid; inside a burst tvalid stays high from one command to the next.
	task automatic send_command(input op_t op, input elem_t v, input logic [8:0] ix,
			input logic [8:0] ixe, input logic typed, input res_t typed_res);
		int gap;
		res_t r;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, ixe, ix, v, op};
		do @(posedge clk); while (s_tready !== 1'b1);
		apply_to_ring(op, v, ix, ixe, r);
		owed_results.push_back(typed ? typed_res : r);
	endtask

	// The capacity is only written while the block is idle: the sender stops, every
	// owed result must have arrived, and a short pause lets the sequencer settle.
	task automatic write_capacity(input logic [8:0] v);
		int c;
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		// Zero is taken as one slot and anything above the depth as the depth.
		c = v;
		if (c == 0) c = 1;
		if (c > MAX_DEPTH) c = MAX_DEPTH;
		ring_span = c;
		ring_head = 0;
		ring_tail = 0;
		ring_fill = 0;
		burst_left = 0;
	endtask

	function automatic row_t cmd_row(input logic typed, input op_t op, input elem_t v,
			input logic [8:0] ix, input logic [8:0] ixe, input elem_t rd, input st_t st,
			input cnt_t fill, input logic full, input logic empty);
		row_t r;
		r = '0;
		r.opcode = op;
		r.value = v;
		r.index = ix;
		r.index_end = ixe;
		r.typed = typed;
		r.result.read_data = rd;
		r.result.status = st;
		r.result.fill_count = fill;
		r.result.is_full = full;
		r.result.is_empty = empty;
		return r;
	endfunction

	// Draws an opcode from the weights of a mix. Thresholds are cumulative, in percent,
	// in the order push back, push front, insert, pop back, pop front, read at,
	// read front, read back, erase; what is left over is clear.
	function automatic op_t pick_op(input mix_t mix);
		logic [8:0][7:0] t;
		int r;
		int k;
		case (mix)
			MIX_GROW:   t = {8'd98, 8'd90, 8'd85, 8'd80, 8'd72, 8'd66, 8'd58, 8'd46, 8'd28};
			MIX_SHRINK: t = {8'd97, 8'd82, 8'd77, 8'd72, 8'd64, 8'd44, 8'd24, 8'd18, 8'd10};
			MIX_FILL:   t = {8'd100, 8'd100, 8'd97, 8'd95, 8'd90, 8'd90, 8'd90, 8'd80, 8'd60};
			default:    t = {8'd98, 8'd88, 8'd82, 8'd76, 8'd64, 8'd52, 8'd40, 8'd30, 8'd16};
		endcase
		r = $urandom_range(0, 99);
		for (k = 0; k < 9; k++)
			if (r < t[k]) break;
		case (k)
			0: return OP_PUSH_BACK;
			1: return OP_PUSH_FRONT;
			2: return OP_INSERT;
			3: return OP_POP_BACK;
			4: return OP_POP_FRONT;
			5: return OP_READ_AT;
			6: return OP_READ_FRONT;
			7: return OP_READ_BACK;
			8: return OP_ERASE;
			default: return OP_CLEAR;
		endcase
	endfunction

	// Builds one random command. Most commands are well formed for the present fill,
	// with random content; about one in ten indexed ones carries a bad position or range,
	// and a few are pure noise over every field, the spare opcodes included.
	task automatic random_command(input mix_t mix);
		op_t op;
		elem_t v;
		logic [8:0] ix;
		logic [8:0] ixe;
		bit bad;
		int span;
		int last;
		v = elem_t'($urandom_range(0, 255));
		ix = 9'($urandom_range(0, 511));
		ixe = 9'($urandom_range(0, 511));
		bad = $urandom_range(0, 9) == 0;
		if ($urandom_range(0, 99) < 5) begin
			op = op_t'($urandom_range(0, 15));
		end else begin
			op = pick_op(mix);
			case (op)
				OP_READ_AT: begin
					if (!bad && ring_fill > 0) ix = 9'($urandom_range(0, ring_fill - 1));
					else ix = 9'($urandom_range(ring_fill, 511));
				end
				OP_INSERT: begin
					if (!bad) ix = 9'($urandom_range(0, ring_fill));
					else ix = 9'($urandom_range(ring_fill + 1, 511));
				end
				OP_ERASE: begin
					if (!bad && ring_fill > 0) begin
						// Short ranges keep the shifting cheap; now and then a long one.
						ix = 9'($urandom_range(0, ring_fill - 1));
						span = ($urandom_range(0, 7) == 0) ? ring_fill : 6;
						last = ix + $urandom_range(1, span);
						ixe = 9'((last > ring_fill) ? ring_fill : last);
					end else if ($urandom_range(0, 1) == 1) begin
						ixe = 9'($urandom_range(0, ring_fill));
						ix = 9'($urandom_range(ixe, 511));
					end else begin
						ixe = 9'($urandom_range(ring_fill + 1, 511));
					end
				end
				default: begin
				end
			endcase
		end
		send_command(op, v, ix, ixe, 1'b0, '0);
	endtask

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			if (mismatches < 40)
				$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: checks every result transfer against the oldest owed result, then
	// decides tready for the next cycle. A long hold overrides the normal pattern,
	// which switches at random between always ready, coin flips, mostly stalled and
	// a fixed on-off rhythm.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got = m_tdata[21:0];
			if (owed_results.size() == 0) begin
				if (mismatches < 40)
					$display("%0t ns: result transfer expected none actual %0h", $time, got);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				report_field("read_data", want.read_data, got.read_data);
				report_field("status", want.status, got.status);
				report_field("fill_count", want.fill_count, got.fill_count);
				report_field("is_full", want.is_full, got.is_full);
				report_field("is_empty", want.is_empty, got.is_empty);
			end
		end
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = 400;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 300);
			end
			mode_left--;
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1) == 1;
				2: m_tready <= $urandom_range(0, 3) == 0;
				default: m_tready <= (rx_cycle % 8) < 3;
			endcase
		end
	end

	initial begin
		row_t row;
		mix_t mix;
		int phase;
		int k;
		int n;
		int guard;
		logic [8:0] cap;

		// Reset is held once, at the start of the run.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity: the failures on an empty buffer, both
		// ends, the extreme values and indexes, the spare opcodes and clear. Then one
		// slot, so that full is reached at once and the ordering of the insert checks
		// shows.
		directed_rows.push_back(cmd_row(1'b1, OP_POP_BACK, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_EMPTY, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_FRONT, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_EMPTY, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_BACK, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_EMPTY, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_AT, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_RANGE, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_ERASE, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_ERASE, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_ERASE, 8'h00, 9'd0, 9'd1,
		                                8'h00, ST_RANGE, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_INSERT, 8'h11, 9'd1, 9'd0,
		                                8'h00, ST_RANGE, 9'd0, 1'b0, 1'b1));
		directed_rows.push_back(cmd_row(1'b1, OP_PUSH_BACK, 8'hFF, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd1, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_PUSH_FRONT, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd2, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_FRONT, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd2, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_BACK, 8'h00, 9'd0, 9'd0,
		                                8'hFF, ST_OK, 9'd2, 1'b0, 1'b0));
		// Insert in the back half, then at the very front.
		directed_rows.push_back(cmd_row(1'b0, OP_INSERT, 8'hA5, 9'd1, 9'd0,
		                                '0, ST_OK, '0, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b0, OP_INSERT, 8'h5A, 9'd0, 9'd0,
		                                '0, ST_OK, '0, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b0, OP_READ_AT, 8'h00, 9'd3, 9'd0,
		                                '0, ST_OK, '0, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_READ_AT, 8'h00, 9'h1FF, 9'h1FF,
		                                8'h00, ST_RANGE, 9'd4, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_SPARE_HIGH, 8'hFF, 9'h1FF, 9'h1FF,
		                                8'h00, ST_OK, 9'd4, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_SPARE_LOW, 8'hFF, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd4, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b0, OP_ERASE, 8'h00, 9'd1, 9'd3,
		                                '0, ST_OK, '0, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_ERASE, 8'h00, 9'd2, 9'd1,
		                                8'h00, ST_ERASE, 9'd2, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_ERASE, 8'h00, 9'd0, 9'h1FF,
		                                8'h00, ST_RANGE, 9'd2, 1'b0, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_CLEAR, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd0, 1'b0, 1'b1));
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_value = 9'd1;
		directed_rows.push_back(row);
		directed_rows.push_back(cmd_row(1'b1, OP_PUSH_BACK, 8'h3C, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd1, 1'b1, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_PUSH_FRONT, 8'h77, 9'd0, 9'd0,
		                                8'h00, ST_FULL, 9'd1, 1'b1, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_INSERT, 8'h77, 9'd2, 9'd0,
		                                8'h00, ST_RANGE, 9'd1, 1'b1, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_INSERT, 8'h77, 9'd0, 9'd0,
		                                8'h00, ST_FULL, 9'd1, 1'b1, 1'b0));
		directed_rows.push_back(cmd_row(1'b1, OP_POP_FRONT, 8'h00, 9'd0, 9'd0,
		                                8'h00, ST_OK, 9'd0, 1'b0, 1'b1));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg)
				write_capacity(row.cfg_value);
			else
				send_command(row.opcode, row.value, row.index, row.index_end,
				             row.typed, row.result);
		end

		// Random part, in phases of one capacity each. The extremes of the register
		// come up, including zero and values beyond the depth. The third phase fills
		// the largest ring to the top before it mixes.
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: cap = 9'd0;
				1: cap = 9'd2;
				2: cap = 9'h1FF;
				3: cap = 9'd3;
				4: cap = 9'd256;
				5: cap = 9'($urandom_range(4, 16));
				6: cap = 9'd300;
				7: cap = 9'($urandom_range(1, 40));
				8: cap = 9'd255;
				default: cap = 9'($urandom_range(1, 511));
			endcase
			write_capacity(cap);
			n = (phase == 2) ? 500 : 170;
			mix = MIX_BALANCED;
			for (k = 0; k < n; k++) begin
				if (k % 40 == 0)
					mix = mix_t'($urandom_range(0, 2));
				if (phase == 2 && k < 300)
					mix = MIX_FILL;
				// Long receiver holds while the sender keeps offering, so the result
				// register fills and the block must stall its input.
				if ((phase == 4 && k == 50) || (phase == 7 && k == 20))
					hold_requests++;
				random_command(mix);
			end
		end

		// Wait for the last results, then watch a while longer for stray transfers.
		s_tvalid <= 1'b0;
		guard = 0;
		while (owed_results.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (600) @(posedge clk);
		if (owed_results.size() != 0) begin
			$display("%0t ns: results expected %0d more actual none", $time,
			         owed_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
